### src/urt_pkg.sv
// urt_pkg: shared types and constants for the uri route tokenizer
// used by urt_front, urt_queue, urt_back and uri_route_tokenizer
`timescale 1ns / 1ps
package urt_pkg;

  // result kinds
  localparam logic [1:0] KIND_SCHEME  = 2'd0;
  localparam logic [1:0] KIND_TARGET  = 2'd1;
  localparam logic [1:0] KIND_SEGMENT = 2'd2;
  localparam logic [1:0] KIND_STATUS  = 2'd3;

  // final status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_FEW_SEGS  = 2'd2;

  // characters of interest
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_HASH  = 8'h23;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // one queue entry: up to three byte results, or one status result
  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] seg;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [5:0] off;
    logic [1:0] cnt;
    logic [1:0] stat;
  } urt_entry_t;

endpackage

### src/uri_route_tokenizer.sv
// uri_route_tokenizer: streaming uri splitter, top level
// depends on urt_pkg, urt_front, urt_queue and urt_back
//
//   channel | ports                                   | dir | role
//   in      | in_valid, in_stall, in_uri_byte         | in  | one uri character per transaction
//   out     | out_valid, out_stall, out_token_kind,   | out | token byte or final status
//           | out_segment_index, out_token_byte,      |     |
//           | out_byte_offset, out_status, out_last   |     |
//
// one byte accepted per cycle while in_stall is low; each byte gives zero, one, two
// or three results and the back end sends one result per cycle while out_stall is
// low, so flushed scheme bytes drain more slowly, absorbed by the four-entry queue
// a queued result is loaded from the queue head straight into the output register
// rst_n is synchronous; no clearing pass, the block is ready right after reset
// in_stall rises only while the queue is full; out_stall holds the output register
`timescale 1ns / 1ps
module uri_route_tokenizer #(
  parameter int MAX_TEXT     = 64,
  parameter int MAX_SEGMENTS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_uri_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_token_kind,
  output logic [2:0] out_segment_index,
  output logic [7:0] out_token_byte,
  output logic [5:0] out_byte_offset,
  output logic [1:0] out_status,
  output logic       out_last
);

  logic                q_full;
  logic                q_not_empty;
  logic                push;
  logic                pop;
  urt_pkg::urt_entry_t push_entry;
  urt_pkg::urt_entry_t head;

  urt_front #(
    .MAX_TEXT     (MAX_TEXT),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_uri_byte (in_uri_byte),
    .q_full      (q_full),
    .push        (push),
    .push_entry  (push_entry)
  );

  urt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (head)
  );

  urt_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .not_empty         (q_not_empty),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_token_kind    (out_token_kind),
    .out_segment_index (out_segment_index),
    .out_token_byte    (out_token_byte),
    .out_byte_offset   (out_byte_offset),
    .out_status        (out_status),
    .out_last          (out_last)
  );

endmodule

### src/urt_front.sv
// urt_front: accepts uri bytes, tracks parse phase and token counts,
// and builds one queue entry per byte that yields results; uses urt_pkg
`timescale 1ns / 1ps
module urt_front #(
  parameter int MAX_TEXT     = 64,
  parameter int MAX_SEGMENTS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_uri_byte,
  input  logic               q_full,
  output logic               push,
  output urt_pkg::urt_entry_t push_entry
);

  localparam int TLW = $clog2(MAX_TEXT);
  localparam int SGW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [TLW-1:0] TL_MAX  = TLW'(MAX_TEXT - 1);
  localparam logic [SGW-1:0] SEG_MAX = SGW'(MAX_SEGMENTS);

  localparam logic [2:0] PH_SCHEME = 3'd0;
  localparam logic [2:0] PH_TARGET = 3'd1;
  localparam logic [2:0] PH_PATH   = 3'd2;
  localparam logic [2:0] PH_DONE   = 3'd3;
  localparam logic [2:0] PH_ERROR  = 3'd4;

  logic [2:0]     phase_r, phase_nxt;
  logic [1:0]     held_r, held_nxt;
  logic [TLW-1:0] tl_r, tl_nxt, tl_base;
  logic [SGW-1:0] segs_r, segs_nxt;

  logic           acc;
  logic [7:0]     c;
  logic           end_path;
  logic [1:0]     req;
  logic [1:0]     kind;
  logic [7:0]     b0, b1, b2;
  logic           fail;
  logic           over;
  logic [1:0]     n_emit;
  logic [TLW-1:0] avail;
  logic [TLW+1:0] avail_w, req_w;
  logic [SGW:0]   segs_fin;
  logic [1:0]     stat;
  logic [TLW+5:0] tl_w;
  logic [SGW+2:0] segs_w;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign c        = in_uri_byte;
  assign end_path = (c == urt_pkg::CH_QUERY) || (c == urt_pkg::CH_HASH);

  assign avail    = TL_MAX - tl_r;
  assign avail_w  = {2'b00, avail};
  assign req_w    = (TLW+2)'(req);
  assign over     = req_w > avail_w;
  assign n_emit   = over ? avail_w[1:0] : req;
  assign tl_w     = {6'b000000, tl_r};
  assign segs_w   = {3'b000, segs_r};

  // segments counted at the terminator, including an unfinished one
  assign segs_fin = {1'b0, segs_r} +
                    (SGW+1)'((phase_r == PH_PATH) && (tl_r != '0));

  always_comb begin
    if ((phase_r == PH_SCHEME) || (phase_r == PH_TARGET) || (phase_r == PH_ERROR)) begin
      stat = urt_pkg::ST_MALFORMED;
    end else if (segs_fin >= (SGW+1)'(2)) begin
      stat = urt_pkg::ST_OK;
    end else begin
      stat = urt_pkg::ST_FEW_SEGS;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    tl_base   = tl_r;
    segs_nxt  = segs_r;
    req       = 2'd0;
    kind      = urt_pkg::KIND_SCHEME;
    b0        = c;
    b1        = urt_pkg::CH_NUL;
    b2        = urt_pkg::CH_NUL;
    fail      = 1'b0;
    case (phase_r)
      PH_SCHEME: begin
        case (held_r)
          2'd0: begin
            if (c == urt_pkg::CH_COLON) begin
              held_nxt = 2'd1;
            end else begin
              req = 2'd1;
            end
          end
          2'd1: begin
            if (c == urt_pkg::CH_SLASH) begin
              held_nxt = 2'd2;
            end else begin
              // held ':' was not the separator
              b0 = urt_pkg::CH_COLON;
              b1 = c;
              if (c == urt_pkg::CH_COLON) begin
                req = 2'd1;
              end else begin
                req      = 2'd2;
                held_nxt = 2'd0;
              end
            end
          end
          default: begin
            if (c == urt_pkg::CH_SLASH) begin
              held_nxt = 2'd0;
              if (tl_r == '0) begin
                fail = 1'b1;
              end else begin
                phase_nxt = PH_TARGET;
                tl_base   = '0;
              end
            end else begin
              b0 = urt_pkg::CH_COLON;
              b1 = urt_pkg::CH_SLASH;
              b2 = c;
              if (c == urt_pkg::CH_COLON) begin
                req      = 2'd2;
                held_nxt = 2'd1;
              end else begin
                req      = 2'd3;
                held_nxt = 2'd0;
              end
            end
          end
        endcase
      end
      PH_TARGET: begin
        if (c == urt_pkg::CH_SLASH) begin
          if (tl_r == '0) begin
            fail = 1'b1;
          end else begin
            phase_nxt = PH_PATH;
            tl_base   = '0;
            segs_nxt  = '0;
          end
        end else if (end_path) begin
          fail = 1'b1;
        end else begin
          req  = 2'd1;
          kind = urt_pkg::KIND_TARGET;
        end
      end
      PH_PATH: begin
        if (end_path) begin
          if (tl_r != '0) segs_nxt = segs_r + SGW'(1);
          tl_base   = '0;
          phase_nxt = PH_DONE;
        end else if ((tl_r == '0) && (segs_r >= SEG_MAX)) begin
          fail = 1'b1;
        end else if (c == urt_pkg::CH_SLASH) begin
          if (tl_r != '0) segs_nxt = segs_r + SGW'(1);
          tl_base = '0;
        end else begin
          req  = 2'd1;
          kind = urt_pkg::KIND_SEGMENT;
        end
      end
      default: begin
      end
    endcase
    if (fail || over) phase_nxt = PH_ERROR;
    tl_nxt = tl_base + TLW'(n_emit);
  end

  always_comb begin
    push_entry = '0;
    if (c == urt_pkg::CH_NUL) begin
      push_entry.kind = urt_pkg::KIND_STATUS;
      push_entry.cnt  = 2'd1;
      push_entry.stat = stat;
      push            = acc;
    end else begin
      push_entry.kind  = kind;
      push_entry.seg   = (kind == urt_pkg::KIND_SEGMENT) ? segs_w[2:0] : 3'd0;
      push_entry.byte0 = b0;
      push_entry.byte1 = b1;
      push_entry.byte2 = b2;
      push_entry.off   = tl_w[5:0];
      push_entry.cnt   = n_emit;
      push_entry.stat  = urt_pkg::ST_OK;
      push             = acc && (n_emit != 2'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SCHEME;
      held_r  <= 2'd0;
      tl_r    <= '0;
      segs_r  <= '0;
    end else if (acc) begin
      if (c == urt_pkg::CH_NUL) begin
        phase_r <= PH_SCHEME;
        held_r  <= 2'd0;
        tl_r    <= '0;
        segs_r  <= '0;
      end else begin
        phase_r <= phase_nxt;
        held_r  <= held_nxt;
        tl_r    <= tl_nxt;
        segs_r  <= segs_nxt;
      end
    end
  end

  a_term_resets: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (c == urt_pkg::CH_NUL) |=> (phase_r == PH_SCHEME) && (tl_r == '0))
    else $error("terminator did not return parser to scheme phase");

  a_tl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tl_r <= TL_MAX)
    else $error("token length past limit");

  a_seg_bound: assert property (@(posedge clk) disable iff (!rst_n)
    segs_r <= SEG_MAX)
    else $error("segment count past limit");

endmodule

### src/urt_queue.sv
// urt_queue: short register queue of result entries between front and back
// depends on urt_pkg for the entry type and depth
`timescale 1ns / 1ps
module urt_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  urt_pkg::urt_entry_t push_entry,
  input  logic                pop,
  output logic                full,
  output logic                not_empty,
  output urt_pkg::urt_entry_t head
);

  urt_pkg::urt_entry_t mem_r [urt_pkg::QUEUE_DEPTH];
  logic [urt_pkg::QPTR_W-1:0] wr_r, rd_r;
  logic [urt_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = cnt_r == urt_pkg::QCNT_W'(urt_pkg::QUEUE_DEPTH);
  assign not_empty = cnt_r != '0;
  assign head      = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + urt_pkg::QCNT_W'(1);
    else if (pop && !push) cnt_nxt = cnt_r - urt_pkg::QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + urt_pkg::QPTR_W'(1);
      if (pop) rd_r <= rd_r + urt_pkg::QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");

endmodule

### src/urt_back.sv
// urt_back: walks the head queue entry into the output register one result
// per cycle while out_stall does not hold it; depends on urt_pkg
`timescale 1ns / 1ps
module urt_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                not_empty,
  input  urt_pkg::urt_entry_t head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_token_kind,
  output logic [2:0]          out_segment_index,
  output logic [7:0]          out_token_byte,
  output logic [5:0]          out_byte_offset,
  output logic [1:0]          out_status,
  output logic                out_last
);

  logic       valid_r;
  logic [1:0] idx_r;
  logic       load;
  logic [7:0] sel_byte;
  logic [1:0] kind_r, stat_r;
  logic [2:0] seg_r;
  logic [7:0] byte_r;
  logic [5:0] off_r;
  logic       last_r;

  assign load = not_empty && (!valid_r || !out_stall);
  assign pop  = load && (idx_r == (head.cnt - 2'd1));

  always_comb begin
    case (idx_r)
      2'd0:    sel_byte = head.byte0;
      2'd1:    sel_byte = head.byte1;
      default: sel_byte = head.byte2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      if (load) valid_r <= 1'b1;
      else if (!out_stall) valid_r <= 1'b0;
      if (pop) idx_r <= 2'd0;
      else if (load) idx_r <= idx_r + 2'd1;
    end
  end

  // payload register, loaded with the next result of the head entry
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= head.kind;
      seg_r  <= head.seg;
      byte_r <= sel_byte;
      off_r  <= head.off + 6'(idx_r);
      stat_r <= head.stat;
      last_r <= head.kind == urt_pkg::KIND_STATUS;
    end
  end

  assign out_valid         = valid_r;
  assign out_token_kind    = kind_r;
  assign out_segment_index = seg_r;
  assign out_token_byte    = byte_r;
  assign out_byte_offset   = off_r;
  assign out_status        = stat_r;
  assign out_last          = last_r;

  a_idx_in_entry: assert property (@(posedge clk) disable iff (!rst_n)
    not_empty |-> (idx_r < head.cnt))
    else $error("result index beyond head entry");

endmodule
